>>> rtl/core/novelty_lowest_cost_table_defines.svh
// Assertion macros shared by the novelty table RTL.
`ifndef NOVELTY_LOWEST_COST_TABLE_DEFINES_SVH
`define NOVELTY_LOWEST_COST_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
`define NLCT_ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
	else $error("assertion failed");
`define NLCT_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
	else $error("assertion failed");
`else
`define NLCT_ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define NLCT_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

>>> rtl/core/nlct_pkg.sv
// Package with item types and constants of the novelty table.
`timescale 1ns / 1ps

package nlct_pkg;

	localparam int KEYS_PER_KIND_DEF = 4096;
	localparam int COST_BITS_DEF     = 16;

	localparam int KEY_W   = 12;
	localparam int CIN_W   = 16;
	localparam int SCORE_W = 13;
	localparam int COUNT_W = 12;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	localparam logic KIND_FEATURE = 1'b0;
	localparam logic KIND_FACT    = 1'b1;

	typedef struct packed {
		logic             key_kind;
		logic [KEY_W-1:0] key;
		logic [CIN_W-1:0] cost_estimate;
		logic             last_of_state;
	} key_item_t;

	typedef struct packed {
		logic signed [SCORE_W-1:0] novelty_score;
		logic                      any_novel;
	} score_item_t;

endpackage

>>> rtl/core/novelty_lowest_cost_table.sv
// Novelty scoring over a lowest-cost table held in block memory.
// Key channel (key_valid/key_ready/key_item): one feature or fact key per
// item, with the state's cost estimate and a last-of-state flag.
// Score channel (score_valid/score_ready/score_item): one item per state,
// emitted for the key flagged last; minus the novel count if any key was
// novel, else the worse count.
// Keys flow at one per cycle unless clearing or a waiting score item holds
// them: each key reads its table entry in the cycle after acceptance and
// writes back at once; a write to the same entry by the key just ahead is
// forwarded around the registered read; the score item leaves a register.
// After reset a sweep clears all 2*KEYS_PER_KIND table entries,
// one entry per cycle, with key_ready low until it ends.
// When score_ready is low and a score item waits, keys keep flowing until
// the next last key reaches the compare stage; it then holds there and
// key_ready drops until the waiting score item is taken.
// KEYS_PER_KIND must be a power of two, which the block does not enforce;
// keys wrap modulo KEYS_PER_KIND and costs saturate at 2^COST_BITS-1.
`timescale 1ns / 1ps
`include "novelty_lowest_cost_table_defines.svh"

module novelty_lowest_cost_table #(
	parameter int KEYS_PER_KIND = nlct_pkg::KEYS_PER_KIND_DEF,
	parameter int COST_BITS     = nlct_pkg::COST_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    key_valid,
	output logic                    key_ready,
	input  nlct_pkg::key_item_t     key_item,
	output logic                    score_valid,
	input  logic                    score_ready,
	output nlct_pkg::score_item_t   score_item
);
	import nlct_pkg::*;

	localparam int KEY_BITS = $clog2(KEYS_PER_KIND);
	localparam int SLOT_W   = KEY_BITS + 1;
	localparam int DEPTH    = 2 * KEYS_PER_KIND;
	localparam int ENTRY_W  = COST_BITS + 1;
	localparam logic [63:0] COST_MAX_W = (64'd1 << COST_BITS) - 64'd1;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DEPTH - 1);

	logic [ENTRY_W-1:0] mem [DEPTH];

	logic                 clr_q;
	logic [SLOT_W-1:0]    clr_cnt_q;

	logic                 valid_s1;
	logic [SLOT_W-1:0]    slot_s1;
	logic [COST_BITS-1:0] cost_s1;
	logic                 last_s1;
	logic [ENTRY_W-1:0]   rdata_s1;

	logic                 wr_valid_q;
	logic [SLOT_W-1:0]    wr_slot_q;
	logic [ENTRY_W-1:0]   wr_entry_q;

	logic [COUNT_W-1:0]   novel_q;
	logic [COUNT_W-1:0]   worse_q;

	logic                 out_valid_q;
	score_item_t          out_item_q;

	logic                 key_accept;
	logic                 s1_go;
	logic [31:0]          key_ext;
	logic [SLOT_W-1:0]    slot_in;
	logic [63:0]          cost_ext;
	logic [COST_BITS-1:0] cost_sat;
	logic [ENTRY_W-1:0]   entry;
	logic                 is_novel;
	logic                 is_worse;
	logic                 s1_write;
	logic [COUNT_W-1:0]   novel_nx;
	logic [COUNT_W-1:0]   worse_nx;
	logic                 mem_we;
	logic [SLOT_W-1:0]    mem_addr;
	logic [ENTRY_W-1:0]   mem_wdata;
	score_item_t          score_nx;

	assign s1_go      = !(last_s1 && out_valid_q && !score_ready);
	assign key_ready  = !clr_q && (!valid_s1 || s1_go);
	assign key_accept = key_valid && key_ready;

	assign key_ext  = {{(32 - KEY_W){1'b0}}, key_item.key};
	assign slot_in  = {key_item.key_kind, key_ext[KEY_BITS-1:0]};
	assign cost_ext = {{(64 - CIN_W){1'b0}}, key_item.cost_estimate};
	assign cost_sat = (cost_ext > COST_MAX_W) ? COST_MAX_W[COST_BITS-1:0]
		: cost_ext[COST_BITS-1:0];

	assign entry    = (wr_valid_q && wr_slot_q == slot_s1) ? wr_entry_q : rdata_s1;
	assign is_novel = !entry[ENTRY_W-1] || (cost_s1 < entry[COST_BITS-1:0]);
	assign is_worse = entry[ENTRY_W-1] && (cost_s1 > entry[COST_BITS-1:0]);
	assign s1_write = valid_s1 && s1_go && is_novel;

	assign novel_nx = (is_novel && novel_q != COUNT_MAX) ? novel_q + COUNT_W'(1) : novel_q;
	assign worse_nx = (is_worse && worse_q != COUNT_MAX) ? worse_q + COUNT_W'(1) : worse_q;

	always_comb begin
		score_nx.any_novel = (novel_nx != '0);
		if (score_nx.any_novel) begin
			score_nx.novelty_score = SCORE_W'(0) - {1'b0, novel_nx};
		end else begin
			score_nx.novelty_score = {1'b0, worse_nx};
		end
	end

	assign mem_we    = clr_q || s1_write;
	assign mem_addr  = clr_q ? clr_cnt_q : slot_s1;
	assign mem_wdata = clr_q ? '0 : {1'b1, cost_s1};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (key_accept) begin
			rdata_s1 <= mem[slot_in];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + SLOT_W'(1);
			if (clr_cnt_q == LAST_SLOT) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (key_accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (key_accept) begin
			slot_s1 <= slot_in;
			cost_s1 <= cost_sat;
			last_s1 <= key_item.last_of_state;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_valid_q <= 1'b0;
		end else if (valid_s1 && s1_go) begin
			wr_valid_q <= is_novel;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_write) begin
			wr_slot_q  <= slot_s1;
			wr_entry_q <= {1'b1, cost_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			novel_q <= '0;
			worse_q <= '0;
		end else if (valid_s1 && s1_go) begin
			if (last_s1) begin
				novel_q <= '0;
				worse_q <= '0;
			end else begin
				novel_q <= novel_nx;
				worse_q <= worse_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && s1_go && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (score_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && s1_go && last_s1) begin
			out_item_q <= score_nx;
		end
	end

	assign score_valid = out_valid_q;
	assign score_item  = out_item_q;

	`NLCT_ASSERT_IMPLIES(a_no_key_while_clearing, clk, arst_n, clr_q, !key_ready)
	`NLCT_ASSERT_IMPLIES(a_hold_stalled_stage, clk, arst_n, valid_s1 && !s1_go, !key_ready)
	`NLCT_ASSERT_IMPLIES(a_novel_score_negative, clk, arst_n,
		score_valid && score_item.any_novel, score_item.novelty_score[SCORE_W-1])
	`NLCT_ASSERT_NEXT(a_counters_clear_after_last, clk, arst_n,
		valid_s1 && s1_go && last_s1, novel_q == '0 && worse_q == '0)

endmodule

>>> sim/novelty_lowest_cost_table_test.sv
// Self-checking testbench for novelty_lowest_cost_table: directed and random key items.
`timescale 1ns / 1ps

module novelty_lowest_cost_table_test;
	import nlct_pkg::*;

	localparam int TABLE_SLOTS  = 2 * KEYS_PER_KIND_DEF;
	localparam int RANDOM_KEYS  = 1450;
	localparam int HOLD_CYCLES  = 400;
	localparam int IDLE_LIMIT   = 30000;
	localparam int SETTLE_TICKS = 10;

	typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE} rx_mode_e;

	logic        clk;
	logic        arst_n;
	logic        key_valid;
	logic        key_ready;
	key_item_t   key_item;
	logic        score_valid;
	logic        score_ready;
	score_item_t score_item;

	bit                 seen_slot [TABLE_SLOTS];
	logic [CIN_W-1:0]   lowest_cost [TABLE_SLOTS];
	logic [COUNT_W-1:0] novel_cnt;
	logic [COUNT_W-1:0] worse_cnt;
	score_item_t        pending_scores [$];

	int  err_count;
	int  keys_sent;
	int  scores_checked;
	int  novel_scores;
	int  worse_scores;
	int  flat_scores;
	int  idle_ticks;
	int  burst_left;
	bit  hold_scores;
	int  holds_done;

	novelty_lowest_cost_table i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.key_valid  (key_valid),
		.key_ready  (key_ready),
		.key_item   (key_item),
		.score_valid(score_valid),
		.score_ready(score_ready),
		.score_item (score_item)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void score_key(input key_item_t it);
		logic [KEY_W:0] slot;
		score_item_t    s;
		slot = {it.key_kind, it.key};
		if (!seen_slot[slot] || it.cost_estimate < lowest_cost[slot]) begin
			seen_slot[slot]   = 1'b1;
			lowest_cost[slot] = it.cost_estimate;
			if (novel_cnt != COUNT_MAX)
				novel_cnt++;
		end else if (it.cost_estimate > lowest_cost[slot]) begin
			if (worse_cnt != COUNT_MAX)
				worse_cnt++;
		end
		if (it.last_of_state) begin
			if (novel_cnt != '0) begin
				s.novelty_score = -$signed({1'b0, novel_cnt});
				s.any_novel     = 1'b1;
			end else begin
				s.novelty_score = $signed({1'b0, worse_cnt});
				s.any_novel     = 1'b0;
			end
			pending_scores.push_back(s);
			novel_cnt = '0;
			worse_cnt = '0;
		end
	endfunction

	task automatic pace_keys();
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 8);
			key_valid <= 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
				: $urandom_range(1, 24);
		end else begin
			burst_left--;
		end
	endtask

	task automatic offer_key(input logic kind, input logic [KEY_W-1:0] k,
		input logic [CIN_W-1:0] cost, input logic last);
		key_item_t it;
		it.key_kind      = kind;
		it.key           = k;
		it.cost_estimate = cost;
		it.last_of_state = last;
		key_item  <= it;
		key_valid <= 1'b1;
		do @(posedge clk); while (!key_ready);
		score_key(it);
		keys_sent++;
		@(negedge clk);
		pace_keys();
	endtask

	task automatic wait_scores_drained();
		key_valid <= 1'b0;
		while (pending_scores.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic test_cost_compare();
		offer_key(KIND_FEATURE, 12'd0, 16'd100, 1'b1);
		offer_key(KIND_FEATURE, 12'd0, 16'd100, 1'b1);
		offer_key(KIND_FEATURE, 12'd0, 16'd200, 1'b1);
		offer_key(KIND_FEATURE, 12'd0, 16'd50, 1'b1);
		offer_key(KIND_FEATURE, 12'd0, 16'd60, 1'b0);
		offer_key(KIND_FEATURE, 12'hAAA, 16'd1, 1'b1);
		wait_scores_drained();
	endtask

	task automatic test_field_extremes();
		offer_key(KIND_FACT, 12'hFFF, 16'hFFFF, 1'b0);
		offer_key(KIND_FACT, 12'hFFF, 16'hFFFF, 1'b0);
		offer_key(KIND_FEATURE, 12'hFFF, 16'h0000, 1'b1);
		offer_key(KIND_FACT, 12'h000, 16'h0000, 1'b1);
		offer_key(KIND_FEATURE, 12'hFFF, 16'hFFFF, 1'b0);
		offer_key(KIND_FACT, 12'hFFF, 16'hFFFF, 1'b0);
		offer_key(KIND_FACT, 12'h000, 16'h0001, 1'b1);
		offer_key(KIND_FACT, 12'hAAA, 16'h5555, 1'b0);
		offer_key(KIND_FEATURE, 12'h555, 16'hAAAA, 1'b1);
		offer_key(KIND_FACT, 12'h555, 16'hAAAA, 1'b0);
		offer_key(KIND_FACT, 12'h555, 16'hAAAB, 1'b1);
		wait_scores_drained();
	endtask

	task automatic test_score_backpressure();
		int i;
		hold_scores = 1'b1;
		for (i = 0; i < 80; i++)
			offer_key(1'($urandom_range(0, 1)), 12'($urandom_range(0, 7) * 511),
				16'(2000 + $urandom_range(0, 6)), i[0]);
		wait_scores_drained();
	endtask

	task automatic test_random_states();
		int               sent;
		int               run_len;
		int               i;
		int               pick;
		logic             kind;
		logic [KEY_W-1:0] k;
		logic [CIN_W-1:0] c;
		sent = 0;
		while (sent < RANDOM_KEYS) begin
			run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24)
				: $urandom_range(1, 6);
			for (i = 0; i < run_len; i++) begin
				kind = 1'($urandom_range(0, 1));
				pick = $urandom_range(0, 9);
				k = (pick < 6) ? 12'($urandom_range(0, 23) * 171) : 12'($urandom_range(0, 4095));
				pick = $urandom_range(0, 19);
				if (pick < 12)
					c = 16'(1000 + $urandom_range(0, 12));
				else if (pick < 17)
					c = 16'($urandom);
				else
					c = pick[0] ? 16'hFFFF : 16'h0000;
				offer_key(kind, k, c, i == run_len - 1);
				sent++;
			end
		end
		wait_scores_drained();
	endtask

	initial begin
		rx_mode_e rx_mode;
		int       mode_left;
		score_ready = 1'b0;
		mode_left   = 0;
		rx_mode     = RX_OPEN;
		forever begin
			@(negedge clk);
			if (hold_scores) begin
				score_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_scores = 1'b0;
				holds_done++;
			end else begin
				if (mode_left == 0) begin
					rx_mode   = rx_mode_e'($urandom_range(0, 2));
					mode_left = $urandom_range(16, 120);
				end
				mode_left--;
				case (rx_mode)
					RX_OPEN: begin
						score_ready <= 1'b1;
					end
					RX_HALF: begin
						score_ready <= 1'($urandom_range(0, 1));
					end
					default: begin
						score_ready <= ($urandom_range(0, 3) == 0);
					end
				endcase
			end
		end
	end

	always @(posedge clk) begin
		score_item_t exp;
		if (arst_n && score_valid && score_ready) begin
			if (pending_scores.size() == 0) begin
				$error("score item with none expected: novelty_score %0d any_novel %0b",
					$signed(score_item.novelty_score), score_item.any_novel);
				err_count++;
			end else begin
				exp = pending_scores.pop_front();
				scores_checked++;
				if (exp.any_novel)
					novel_scores++;
				else if (exp.novelty_score != '0)
					worse_scores++;
				else
					flat_scores++;
				if (score_item.novelty_score !== exp.novelty_score) begin
					$error("novelty_score: expected %0d, got %0d",
						$signed(exp.novelty_score), $signed(score_item.novelty_score));
					err_count++;
				end
				if (score_item.any_novel !== exp.any_novel) begin
					$error("any_novel: expected %0b, got %0b",
						exp.any_novel, score_item.any_novel);
					err_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (key_valid && key_ready) || (score_valid && score_ready))
			idle_ticks <= 0;
		else
			idle_ticks <= idle_ticks + 1;
		if (idle_ticks >= IDLE_LIMIT) begin
			$display("timeout after %0d idle cycles, %0d scores outstanding",
				idle_ticks, pending_scores.size());
			$display("novelty_lowest_cost_table verification failed");
			$finish;
		end
	end

	initial begin
		arst_n           = 1'b0;
		key_valid        = 1'b0;
		key_item         = '0;
		novel_cnt        = '0;
		worse_cnt        = '0;
		err_count        = 0;
		keys_sent        = 0;
		scores_checked   = 0;
		novel_scores     = 0;
		worse_scores     = 0;
		flat_scores      = 0;
		idle_ticks       = 0;
		burst_left       = 0;
		hold_scores      = 1'b0;
		holds_done       = 0;
		foreach (seen_slot[i])
			seen_slot[i] = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_cost_compare();
		test_field_extremes();
		test_score_backpressure();
		test_random_states();

		repeat (SETTLE_TICKS) @(posedge clk);
		$display("covered %0d keys, %0d scores: %0d novel, %0d worse, %0d flat",
			keys_sent, scores_checked, novel_scores, worse_scores, flat_scores);
		$display("long score holds %0d", holds_done);
		if (err_count == 0)
			$display("novelty_lowest_cost_table verification clean");
		else
			$display("novelty_lowest_cost_table verification failed");
		$finish;
	end

endmodule
